// ===== sv/twc_pkg.sv =====
package twc_pkg;

    // Default rates: CPU clock that drives the sequencer and the audio sample rate.
    localparam int CPU_CLOCK_HZ_DEF   = 1789772;
    localparam int SAMPLE_RATE_HZ_DEF = 44100;

    localparam int PHASE_W  = 27;
    localparam int PERIOD_W = 11;
    localparam int LEN_W    = 8;
    localparam int LIN_W    = 7;
    localparam int STEP_W   = 5;
    localparam int SAMPLE_W = 10;

    // Action codes carried by an input word.
    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    // Register indexes for writes.
    localparam logic [1:0] REG_LINEAR    = 2'd0;
    localparam logic [1:0] REG_SWEEP     = 2'd1;
    localparam logic [1:0] REG_PERIOD_LO = 2'd2;
    localparam logic [1:0] REG_PERIOD_HI = 2'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] reg_addr;
        logic [7:0] reg_data;
    } item_t;

    typedef struct packed {
        logic                load;
        logic [SAMPLE_W-1:0] value;
    } smp_load_t;

    localparam logic [LEN_W-1:0] LENGTH_TABLE [32] = '{
        8'h0A, 8'hFE, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
        8'hA0, 8'h08, 8'h3C, 8'h0A, 8'h0E, 8'h0C, 8'h1A, 8'h0E,
        8'h0C, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
        8'hC0, 8'h18, 8'h48, 8'h1A, 8'h10, 8'h1C, 8'h20, 8'h1E
    };

    // The 32-step sequence rises 0..15 and then falls 15..0.
    function automatic logic [3:0] height_of(input logic [STEP_W-1:0] step);
        height_of = step[4] ? ~step[3:0] : step[3:0];
    endfunction

endpackage

// ===== sv/twc_in_stage.sv =====
module twc_in_stage
    import twc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [1:0] reg_addr,
    input  logic [7:0] reg_data,
    input  logic       fire,
    output logic       item_vld,
    output item_t      item
);

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    // The stage can take a word when empty or when its word moves on this cycle.
    assign in_ready = !vld_reg || fire;
    assign vld_next = in_ready ? in_valid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{action: action, reg_addr: reg_addr, reg_data: reg_data};
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

// ===== sv/twc_core.sv =====
module twc_core
    import twc_pkg::*;
#(
    parameter int CPU_CLOCK_HZ   = CPU_CLOCK_HZ_DEF,
    parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_HZ_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  logic      item_vld,
    input  item_t     item,
    input  logic      out_free,
    output logic      fire,
    output smp_load_t smp
);

    localparam int PROD_W = PHASE_W + 2;
    localparam logic [PHASE_W:0]  CPU_INC = (PHASE_W+1)'(CPU_CLOCK_HZ);
    localparam logic [PROD_W-1:0] SR_K    = PROD_W'(SAMPLE_RATE_HZ);
    localparam logic [PHASE_W-1:0] PHASE_MAX = {PHASE_W{1'b1}};

    logic                enable_reg;
    logic                hold_reg,      hold_next;
    logic [LIN_W-1:0]    reload_val_reg, reload_val_next;
    logic [PERIOD_W-1:0] period_reg,    period_next;
    logic [LEN_W-1:0]    length_reg,    length_next;
    logic                reload_reg,    reload_next;
    logic [LIN_W-1:0]    lin_reg,       lin_next;
    logic [PHASE_W-1:0]  phase_reg,     phase_next;
    logic [STEP_W-1:0]   step_reg,      step_next;
    logic [PHASE_W-1:0]  thresh_reg,    thresh_next;

    logic                is_sample;
    logic                audible;
    logic [LIN_W-1:0]    lin_base;
    logic [PROD_W-1:0]   thresh_prod;
    logic [PHASE_W:0]    acc_sum;
    logic [PHASE_W:0]    acc_wrap;

    assign is_sample = (item.action == ACT_SAMPLE);
    assign fire      = item_vld && (!is_sample || out_free);
    assign audible   = (length_reg != '0) && (lin_reg != '0) && (period_reg != '0);

    // Sequencer accumulator: add the CPU clock, wrap on reaching the period threshold.
    assign acc_sum  = {1'b0, phase_reg} + CPU_INC;
    assign acc_wrap = acc_sum - {1'b0, thresh_reg};

    // The threshold tracks the period, so only an add, a subtract and a compare sit on the sample path.
    assign thresh_prod = SR_K * (PROD_W'(period_next) + PROD_W'(1));

    always_comb
    begin
        hold_next       = hold_reg;
        reload_val_next = reload_val_reg;
        period_next     = period_reg;
        length_next     = length_reg;
        reload_next     = reload_reg;
        lin_next        = lin_reg;
        phase_next      = phase_reg;
        step_next       = step_reg;
        lin_base        = enable_reg ? lin_reg : '0;

        if (fire)
        begin
            case (item.action)
                ACT_WRITE:
                begin
                    case (item.reg_addr)
                        REG_LINEAR:
                        begin
                            hold_next       = item.reg_data[7];
                            reload_val_next = item.reg_data[6:0];
                        end
                        REG_PERIOD_LO:
                        begin
                            period_next = {period_reg[10:8], item.reg_data};
                        end
                        REG_PERIOD_HI:
                        begin
                            period_next = {item.reg_data[2:0], period_reg[7:0]};
                            length_next = LENGTH_TABLE[item.reg_data[7:3]];
                            reload_next = 1'b1;
                        end
                        default:
                        begin
                            // The sweep register has no function in this channel.
                        end
                    endcase
                end
                ACT_TICK:
                begin
                    if (reload_reg)
                    begin
                        lin_next = reload_val_reg;
                    end
                    else if (lin_base != '0)
                    begin
                        lin_next = lin_base - LIN_W'(1);
                    end
                    else
                    begin
                        lin_next = lin_base;
                    end
                    if (!hold_reg)
                    begin
                        reload_next = 1'b0;
                    end
                end
                ACT_SAMPLE:
                begin
                    if (audible)
                    begin
                        if (acc_sum >= {1'b0, thresh_reg})
                        begin
                            step_next  = step_reg + STEP_W'(1);
                            phase_next = acc_wrap[PHASE_W] ? PHASE_MAX : acc_wrap[PHASE_W-1:0];
                        end
                        else
                        begin
                            phase_next = acc_sum[PHASE_W-1:0];
                        end
                    end
                end
                default:
                begin
                    // Unused action code: dropped without effect.
                end
            endcase
        end
        thresh_next = thresh_prod[PHASE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            hold_reg       <= 1'b0;
            reload_val_reg <= '0;
            period_reg     <= '0;
            length_reg     <= '0;
            reload_reg     <= 1'b0;
            lin_reg        <= '0;
            phase_reg      <= '0;
            step_reg       <= '0;
            thresh_reg     <= SR_K[PHASE_W-1:0];
        end
        else
        begin
            if (cfg_wr_en)
            begin
                enable_reg <= cfg_wr_data;
            end
            hold_reg       <= hold_next;
            reload_val_reg <= reload_val_next;
            period_reg     <= period_next;
            length_reg     <= length_next;
            reload_reg     <= reload_next;
            lin_reg        <= lin_next;
            phase_reg      <= phase_next;
            step_reg       <= step_next;
            thresh_reg     <= thresh_next;
        end
    end

    // The answer reflects the step reached after this request's advance.
    assign smp.load  = fire && is_sample;
    assign smp.value = audible ? {height_of(step_next), 6'b0} : '0;

    a_thresh_tracks_period: assert property (@(posedge clk) disable iff (!rst_n)
        thresh_reg == PHASE_W'(SR_K * (PROD_W'(period_reg) + PROD_W'(1))))
        else $error("threshold out of step with period");

    a_silent_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_sample && !audible) |=> $stable(phase_reg) && $stable(step_reg))
        else $error("silent request moved the sequencer");

    a_hi_write_sets_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.action == ACT_WRITE && item.reg_addr == REG_PERIOD_HI) |=> reload_reg)
        else $error("period high write did not arm the reload");

    a_step_moves_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (step_reg == $past(step_reg) || step_reg == $past(step_reg) + STEP_W'(1)))
        else $error("sequence step jumped");

endmodule

// ===== sv/twc_out_reg.sv =====
module twc_out_reg
    import twc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  smp_load_t           smp,
    output logic                out_free,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SAMPLE_W-1:0] sample
);

    logic                vld_reg;
    logic                vld_next;
    logic [SAMPLE_W-1:0] sample_reg;

    // Free when empty or when the waiting word is taken this cycle.
    assign out_free = !vld_reg || out_ready;
    assign vld_next = smp.load || (vld_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp.load)
        begin
            sample_reg <= smp.value;
        end
    end

    assign out_valid = vld_reg;
    assign sample    = sample_reg;

endmodule

// ===== sv/triangle_wave_channel_unit.sv =====
// Channel   Direction  Handshake               Word
// input     in         in_valid / in_ready     action, reg_addr, reg_data
// output    out        out_valid / out_ready   sample
// config    in         cfg_wr_en (no wait)     cfg_wr_data (channel enable)
//
// A word is registered when accepted and acted on once the core can take it; a
// sample request's answer is loaded into the output register at the end of
// that cycle, which raises out_valid.
// With the output drained, one word is accepted every cycle.
// rst_n clears all channel state asynchronously; no clearing pass follows.
// A sample request waits in the input register while an earlier answer is
// still unread; writes and ticks never wait on the output side.
module triangle_wave_channel_unit
    import twc_pkg::*;
#(
    parameter int CPU_CLOCK_HZ   = CPU_CLOCK_HZ_DEF,
    parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_HZ_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          action,
    input  logic [1:0]          reg_addr,
    input  logic [7:0]          reg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SAMPLE_W-1:0] sample
);

    logic      item_vld;
    item_t     item;
    logic      fire;
    logic      out_free;
    smp_load_t smp;

    // Input register: holds one word until the core can act on it.
    twc_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .reg_addr (reg_addr),
        .reg_data (reg_data),
        .fire     (fire),
        .item_vld (item_vld),
        .item     (item)
    );

    // Core: register file, linear counter, phase accumulator and sequencer.
    // A word is consumed when it produces no answer or the output slot is free.
    twc_core #(
        .CPU_CLOCK_HZ   (CPU_CLOCK_HZ),
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_vld    (item_vld),
        .item        (item),
        .out_free    (out_free),
        .fire        (fire),
        .smp         (smp)
    );

    // Output register: keeps the answer until the consumer takes it.
    twc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp       (smp),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample    (sample)
    );

endmodule

// ===== test/tb_triangle_wave_channel_unit.sv =====
`timescale 1ns / 1ps

// The testbench drives words into the triangle channel and checks every sample
// answer against a predictor. Each side idles at random, except for one
// stretch with no idling at all.
module tb_triangle_wave_channel_unit;
    import twc_pkg::*;

    // Action code 3 is never decoded by the channel. It is sent as noise.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int  CLK_HALF      = 5;
    localparam int  RESET_CYCLES  = 8;
    localparam int  SETTLE_CYCLES = 6;
    localparam int  LIMIT_CYCLES  = 400000;
    localparam int  PHASE_WORDS   = 100;
    localparam int  IDLE_PERCENT  = 14;

    localparam longint unsigned PHASE_CEILING = (64'd1 << PHASE_W) - 1;

    // This is the length table that a write to the period-high register selects from.
    localparam logic [LEN_W-1:0] LENGTH_LOOKUP [32] = '{
        8'h0A, 8'hFE, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
        8'hA0, 8'h08, 8'h3C, 8'h0A, 8'h0E, 8'h0C, 8'h1A, 8'h0E,
        8'h0C, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
        8'hC0, 8'h18, 8'h48, 8'h1A, 8'h10, 8'h1C, 8'h20, 8'h1E
    };

    // The scoreboard keeps its own copy of the channel state. It queues the
    // sample that each accepted request should produce and checks every
    // answer against the oldest entry in that queue.
    class tri_scoreboard;
        bit                  chan_enable;
        bit                  hold;
        logic [LIN_W-1:0]    reload_value;
        logic [PERIOD_W-1:0] period;
        logic [LEN_W-1:0]    length_value;
        bit                  reload_pending;
        logic [LIN_W-1:0]    linear_count;
        logic [PHASE_W-1:0]  phase_acc;
        logic [STEP_W-1:0]   seq_step;

        logic [SAMPLE_W-1:0] pending_samples [$];
        int                  errors;
        int                  answers_checked;
        int                  audible_answers;
        int                  saturations;
        int                  steps_taken;

        function new();
            chan_enable    = 1'b0;
            hold           = 1'b0;
            reload_value   = '0;
            period         = '0;
            length_value   = '0;
            reload_pending = 1'b0;
            linear_count   = '0;
            phase_acc      = '0;
            seq_step       = '0;
            errors         = 0;
            answers_checked = 0;
            audible_answers = 0;
            saturations    = 0;
            steps_taken    = 0;
        endfunction

        // This advances the sequencer for one sample request and returns the level.
        function logic [SAMPLE_W-1:0] render_sample();
            longint unsigned threshold;
            longint unsigned acc;
            logic [3:0]      height;
            if (length_value == 0 || linear_count == 0 || period == 0)
                return '0;
            threshold = longint'(SAMPLE_RATE_HZ_DEF) * (longint'(period) + 1);
            acc = longint'(phase_acc) + longint'(CPU_CLOCK_HZ_DEF);
            if (acc >= threshold)
            begin
                acc      = acc - threshold;
                seq_step = seq_step + 1'b1;
                steps_taken++;
            end
            if (acc > PHASE_CEILING)
            begin
                acc = PHASE_CEILING;
                saturations++;
            end
            phase_acc = acc[PHASE_W-1:0];
            // The first sixteen steps rise and the rest fall back to zero.
            height = seq_step[4] ? 4'(5'd31 - seq_step) : seq_step[3:0];
            return SAMPLE_W'(height) << 6;
        endfunction

        function void note_word(logic [1:0] act, logic [1:0] addr, logic [7:0] data);
            case (act)
                ACT_WRITE:
                begin
                    case (addr)
                        REG_LINEAR:
                        begin
                            hold         = data[7];
                            reload_value = data[6:0];
                        end
                        REG_PERIOD_LO:
                            period = {period[10:8], data};
                        REG_PERIOD_HI:
                        begin
                            period         = {data[2:0], period[7:0]};
                            length_value   = LENGTH_LOOKUP[data[7:3]];
                            reload_pending = 1'b1;
                        end
                        default:
                            ;
                    endcase
                end
                ACT_TICK:
                begin
                    if (!chan_enable)
                        linear_count = '0;
                    if (reload_pending)
                        linear_count = reload_value;
                    else if (linear_count != 0)
                        linear_count = linear_count - 1'b1;
                    if (!hold)
                        reload_pending = 1'b0;
                end
                ACT_SAMPLE:
                    pending_samples.push_back(render_sample());
                default:
                    ;
            endcase
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_sample(logic [SAMPLE_W-1:0] got);
            logic [SAMPLE_W-1:0] want;
            if (pending_samples.size() == 0)
            begin
                report_mismatch($sformatf("sample %0d arrived with no request pending", got));
                return;
            end
            want = pending_samples.pop_front();
            answers_checked++;
            if (want != 0)
                audible_answers++;
            if (got !== want)
                report_mismatch($sformatf("sample got %0d, expected %0d", got, want));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic                cfg_wr_data;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          action;
    logic [1:0]          reg_addr;
    logic [7:0]          reg_data;
    logic                out_valid;
    logic                out_ready;
    logic [SAMPLE_W-1:0] sample;

    tri_scoreboard sb;
    bit            no_idle;
    int            words_sent;
    int            ticks_sent;
    int            cycle_count;

    triangle_wave_channel_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .reg_addr    (reg_addr),
        .reg_data    (reg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample      (sample)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // A watchdog ends a run that hangs waiting for a handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d samples still pending",
                     cycle_count, sb.pending_samples.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The receiver stalls in about 14 percent of cycles. It never stalls in the
    // quiet stretch. Its ready changes only on the falling edge.
    always @(negedge clk)
    begin
        out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Both handshakes are sampled at the rising edge, before the block updates.
    // The answer is checked before a new request is noted. An answer that
    // leaves in the same cycle therefore cannot be matched against a request
    // that has only just been accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_sample(sample);
            if (in_valid && in_ready)
                sb.note_word(action, reg_addr, reg_data);
        end
    end

    // This task is entered and left on a falling edge. The sender may idle at
    // random first. Then it holds the word until the block accepts it.
    task send_word(input logic [1:0] act, input logic [1:0] addr, input logic [7:0] data);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        reg_addr <= addr;
        reg_data <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (act != ACT_UNUSED)
            words_sent++;
        if (act == ACT_TICK)
            ticks_sent++;
    endtask

    // The last answer can arrive while a trailing write or tick is still being
    // handled. A settling wait after the last answer lets that word finish.
    task drain_channel();
        in_valid <= 1'b0;
        while (sb.pending_samples.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // The enable register is written only while the channel is idle.
    task set_enable(input bit en);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= en;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.chan_enable = en;
    endtask

    // Most traffic is well formed. A sequence sets up the linear counter, the
    // period and the length, ticks once to load the counter, and then sends a
    // burst of sample requests with a few ticks mixed in. Short periods make
    // the sequencer step on every sample and drive the accumulator toward its
    // ceiling. The remaining traffic is single random words, and some of those
    // use the unused action code.
    task run_phase(input int quota);
        int         stop_at;
        int         burst;
        logic [7:0] lo;
        logic [2:0] hi;
        stop_at = words_sent + quota;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                if ($urandom_range(0, 99) < 45)
                begin
                    lo = 8'($urandom_range(1, 8));
                    hi = 3'd0;
                end
                else
                begin
                    lo = 8'($urandom);
                    hi = 3'($urandom);
                end
                send_word(ACT_WRITE, REG_LINEAR,
                          {1'($urandom), ($urandom_range(0, 9) == 0) ? 7'd0
                                                                     : 7'($urandom_range(1, 127))});
                send_word(ACT_WRITE, REG_PERIOD_LO, lo);
                send_word(ACT_WRITE, REG_PERIOD_HI, {5'($urandom), hi});
                send_word(ACT_TICK, 2'($urandom), 8'($urandom));
                burst = ($urandom_range(0, 19) == 0) ? 90 : $urandom_range(1, 24);
                repeat (burst)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_word(ACT_TICK, 2'($urandom), 8'($urandom));
                    else
                        send_word(ACT_SAMPLE, 2'($urandom), 8'($urandom));
                end
            end
            else
            begin
                send_word(2'($urandom), 2'($urandom), 8'($urandom));
            end
        end
    endtask

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        in_valid    = 1'b0;
        action      = ACT_WRITE;
        reg_addr    = REG_LINEAR;
        reg_data    = 8'h00;
        out_ready   = 1'b0;
        no_idle     = 1'b0;
        words_sent  = 0;
        ticks_sent  = 0;
        cycle_count = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. A sample request straight out of reset must be
        // silent, and the unused action code and the sweep register must
        // change nothing.
        send_word(ACT_SAMPLE, REG_LINEAR, 8'h00);
        send_word(ACT_UNUSED, REG_PERIOD_HI, 8'hFF);
        send_word(ACT_WRITE, REG_SWEEP, 8'hFF);
        send_word(ACT_SAMPLE, REG_SWEEP, 8'hFF);
        drain_channel();
        set_enable(1'b1);

        // All-ones values give hold on, the largest reload value, the longest
        // period and the last length entry.
        send_word(ACT_WRITE, REG_LINEAR, 8'hFF);
        send_word(ACT_WRITE, REG_PERIOD_LO, 8'hFF);
        send_word(ACT_WRITE, REG_PERIOD_HI, 8'hFF);
        send_word(ACT_TICK, REG_LINEAR, 8'h00);
        repeat (3) send_word(ACT_SAMPLE, REG_LINEAR, 8'h00);

        // A zero period silences the channel even while length and count are set.
        send_word(ACT_WRITE, REG_PERIOD_LO, 8'h00);
        send_word(ACT_WRITE, REG_PERIOD_HI, 8'h00);
        send_word(ACT_SAMPLE, REG_LINEAR, 8'h00);

        // The shortest period steps the sequencer on every sample.
        send_word(ACT_WRITE, REG_PERIOD_LO, 8'h01);
        send_word(ACT_WRITE, REG_PERIOD_HI, 8'h08);
        repeat (4) send_word(ACT_SAMPLE, REG_LINEAR, 8'h00);

        // With hold off, the reload flag clears after one tick. The counter
        // then runs down to zero and the channel falls silent.
        send_word(ACT_WRITE, REG_LINEAR, 8'h01);
        send_word(ACT_WRITE, REG_PERIOD_HI, 8'h08);
        send_word(ACT_TICK, REG_LINEAR, 8'h00);
        send_word(ACT_SAMPLE, REG_LINEAR, 8'h00);
        send_word(ACT_TICK, REG_LINEAR, 8'h00);
        send_word(ACT_SAMPLE, REG_LINEAR, 8'h00);
        drain_channel();

        // Random phases run with the enable off in the second and fifth. The third
        // phase runs with no idling on either side.
        for (int ph = 0; ph < 6; ph++)
        begin
            set_enable((ph % 3) != 1);
            no_idle = (ph == 2);
            run_phase(PHASE_WORDS);
            drain_channel();
        end
        no_idle = 1'b0;
        set_enable(1'b0);

        $display("Sent %0d words (%0d ticks) over six enable phases in %0d cycles.",
                 words_sent, ticks_sent, cycle_count);
        $display("Checked %0d samples: %0d audible, %0d steps, %0d saturated accumulations.",
                 sb.answers_checked, sb.audible_answers, sb.steps_taken, sb.saturations);
        if (sb.errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("%0d mismatches", sb.errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/twc_pkg.sv
sv/twc_in_stage.sv
sv/twc_core.sv
sv/twc_out_reg.sv
sv/triangle_wave_channel_unit.sv
test/tb_triangle_wave_channel_unit.sv
